### rtl/core/sra_pkg.sv
`default_nettype none

package sra_pkg;

  localparam int POS_W    = 10;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_SHARE   = 2'd1,
    FN_RELEASE = 2'd2,
    FN_INVALID = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FIFO_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  typedef enum logic {
    CU_INC = 1'b0,
    CU_DEC = 1'b1
  } cu_op_t;

  // compare results of the count unit
  typedef struct packed {
    logic zero;
    logic one;
    logic max;
  } cnt_flags_t;

endpackage

`default_nettype wire

### rtl/core/slot_allocator_with_refcounts_core.sv
`default_nettype none

// Slot allocator with per-slot share counts.
//
// Command channel: a beat is taken on a rising edge with start high and busy
// low (in_func, in_position). Every beat produces exactly one result beat on
// out_slot / out_freed / out_status, marked by out_valid for one cycle; the
// receiver cannot stall it.
// Allocate pops the free FIFO, else takes the next never-used slot, else
// reports exhaustion. Share bumps the slot's count (saturating); release
// drops it and pushes the slot onto the free FIFO when it hits zero, or at
// once if the slot was never shared.
// Timing: the count and FIFO memories are read on the accept edge, the
// count unit and all updates run in the following cycle, and the result is
// shown the cycle after that. A new start is taken in the same cycle the
// previous result is on out_valid.
// Reset: after rst_n the count memory is swept to zero, one entry a cycle,
// and busy stays high until the sweep ends and the first beat can be taken.
module slot_allocator_with_refcounts_core
  import sra_pkg::*;
#(
  parameter int SLOTS      = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [1:0]          in_func,
  input  wire logic [POS_W-1:0]    in_position,
  output      logic                out_valid,
  output      logic [POS_W-1:0]    out_slot,
  output      logic                out_freed,
  output      logic [STATUS_W-1:0] out_status
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX   = SW'(SLOTS - 1);
  localparam logic [SW:0]   SLOTS_FULL = (SW + 1)'(SLOTS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       clr_idx_r, clr_idx_nxt;
  func_t               func_r, func_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SW:0]         fresh_r, fresh_nxt;
  logic [SW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [SW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [SW:0]         occ_r, occ_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_slot_r, out_slot_nxt;
  logic                out_freed_r, out_freed_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // memory ports
  logic                  cnt_we;
  logic [SW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  fifo_we;
  logic [SW-1:0]         fifo_q;
  logic                  mem_re;

  // shared count unit
  cu_op_t                cu_op;
  logic [COUNT_BITS-1:0] cu_result;
  cnt_flags_t            cu_flags;

  logic pos_oob;
  logic fifo_full;

  assign mem_re    = (state_r == S_IDLE);
  assign pos_oob   = (32'(pos_r) >= 32'(SLOTS));
  assign fifo_full = (occ_r == SLOTS_FULL);
  assign cu_op     = (func_r == FN_RELEASE) ? CU_DEC : CU_INC;

  sra_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (mem_re),
    .raddr (SW'(in_position)),
    .rdata (cnt_q)
  );

  // free FIFO storage; read at the head on every accept
  sra_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wr_ptr_r),
    .wdata (SW'(pos_r)),
    .re    (mem_re),
    .raddr (rd_ptr_r),
    .rdata (fifo_q)
  );

  sra_count_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count_unit (
    .op     (cu_op),
    .cnt    (cnt_q),
    .result (cu_result),
    .flags  (cu_flags)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    func_nxt       = func_r;
    pos_nxt        = pos_r;
    fresh_nxt      = fresh_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_freed_nxt  = out_freed_r;
    out_status_nxt = out_status_r;
    cnt_we         = 1'b0;
    cnt_waddr      = SW'(pos_r);
    cnt_wdata      = cu_result;
    fifo_we        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // zero sweep of the count memory after reset
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + SW'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          func_nxt  = func_t'(in_func);
          pos_nxt   = in_position;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = pos_r;
        out_freed_nxt  = 1'b0;
        out_status_nxt = ST_OK;
        if (func_r == FN_ALLOC) begin
          if (occ_r != '0) begin
            out_slot_nxt = POS_W'(fifo_q);
            rd_ptr_nxt   = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + SW'(1);
            occ_nxt      = occ_r - (SW + 1)'(1);
          end else if (fresh_r != SLOTS_FULL) begin
            out_slot_nxt = POS_W'(fresh_r);
            fresh_nxt    = fresh_r + (SW + 1)'(1);
          end else begin
            out_slot_nxt   = '0;
            out_status_nxt = ST_EXHAUSTED;
          end
        end else if (func_r == FN_INVALID || pos_oob) begin
          out_status_nxt = ST_INVALID;
        end else if (func_r == FN_SHARE) begin
          // zero + 1 gives the first share's count of one
          if (!cu_flags.zero && cu_flags.max) begin
            out_status_nxt = ST_SATURATED;
          end else begin
            cnt_we = 1'b1;
          end
        end else begin
          if (!cu_flags.zero && !cu_flags.one) begin
            cnt_we = 1'b1;
          end else if (fifo_full) begin
            out_status_nxt = ST_FIFO_FULL;
          end else begin
            fifo_we    = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + SW'(1);
            occ_nxt    = occ_r + (SW + 1)'(1);
            if (cu_flags.one) begin
              cnt_we        = 1'b1;   // one - 1 writes zero
              out_freed_nxt = 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      fresh_r     <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      fresh_r     <= fresh_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    pos_r        <= pos_nxt;
    out_slot_r   <= out_slot_nxt;
    out_freed_r  <= out_freed_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_freed  = out_freed_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

### rtl/core/sra_ram.sv
`default_nettype none

module sra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sra_count_unit.sv
`default_nettype none

module sra_count_unit
  import sra_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire cu_op_t                op,
  input  wire logic [COUNT_BITS-1:0] cnt,
  output      logic [COUNT_BITS-1:0] result,
  output      cnt_flags_t            flags
);

  // one add/subtract and the compares on the old count
  always_comb begin
    result     = (op == CU_DEC) ? cnt - COUNT_BITS'(1) : cnt + COUNT_BITS'(1);
    flags.zero = (cnt == '0);
    flags.one  = (cnt == COUNT_BITS'(1));
    flags.max  = &cnt;
  end

endmodule

`default_nettype wire

### tb/tb_slot_allocator_with_refcounts_core.sv
`default_nettype none

module tb_slot_allocator_with_refcounts_core;
  import sra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 1024;
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Timeout. The limit takes in the reset sweep too.
  localparam int CYCLE_LIMIT = 200_000;

  // One result beat: slot, freed flag and status.
  typedef struct packed {
    logic [POS_W-1:0]    slot;
    logic                freed;
    logic [STATUS_W-1:0] status;
  } reply_t;

  // Slot ledger: mirrors the allocator state and queues the replies it owes.
  class slot_ledger;
    bit [10:0]           fresh_next;
    bit [POS_W-1:0]      fifo_mem [SLOTS];
    bit [POS_W-1:0]      rd_ptr;
    bit [POS_W-1:0]      wr_ptr;
    bit [10:0]           fifo_fill;
    bit [COUNT_BITS-1:0] counts [SLOTS];
    reply_t              owed [$];
    int                  mismatches;

    function new();
      fresh_next = '0;
      rd_ptr     = '0;
      wr_ptr     = '0;
      fifo_fill  = '0;
      mismatches = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Apply one accepted request; returns the reply it owes.
    function reply_t take_request(func_t f, logic [POS_W-1:0] p);
      reply_t              r;
      bit                  full;
      bit [COUNT_BITS-1:0] c;
      r.slot   = p;
      r.freed  = 1'b0;
      r.status = ST_OK;
      full     = (fifo_fill >= SLOTS);
      c        = counts[p];
      case (f)
        FN_ALLOC: begin
          if (fifo_fill != 0) begin
            r.slot = fifo_mem[rd_ptr];
            rd_ptr++;
            fifo_fill--;
          end else if (fresh_next < SLOTS) begin
            r.slot = fresh_next[POS_W-1:0];
            fresh_next++;
          end else begin
            r.slot   = '0;
            r.status = ST_EXHAUSTED;
          end
        end
        FN_SHARE: begin
          if (c == 0) counts[p] = 1;
          else if (c == CNT_MAX) r.status = ST_SATURATED;
          else counts[p] = c + 1'b1;
        end
        FN_RELEASE: begin
          if (c > 1) begin
            counts[p] = c - 1'b1;
          end else if (full) begin
            r.status = ST_FIFO_FULL;
          end else begin
            fifo_mem[wr_ptr] = p;
            wr_ptr++;
            fifo_fill++;
            if (c == 1) begin
              counts[p] = '0;
              r.freed   = 1'b1;
            end
          end
        end
        default: r.status = ST_INVALID;
      endcase
      owed = {owed, r};
      return r;
    endfunction

    task check_reply(logic [POS_W-1:0] slot, logic freed, logic [STATUS_W-1:0] status);
      reply_t e;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed (slot %0d status %0d)", slot, status));
      end else begin
        e = owed.pop_front();
        if (slot !== e.slot)
          report($sformatf("slot got %0d want %0d", slot, e.slot));
        if (freed !== e.freed)
          report($sformatf("freed got %b want %b (slot %0d)", freed, e.freed, e.slot));
        if (status !== e.status)
          report($sformatf("status got %0d want %0d (slot %0d)", status, e.status, e.slot));
      end
    endtask

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [1:0]          in_func = FN_ALLOC;
  logic [POS_W-1:0]    in_position = '0;
  logic                busy;
  logic                out_valid;
  logic [POS_W-1:0]    out_slot;
  logic                out_freed;
  logic [STATUS_W-1:0] out_status;

  slot_ledger       ledger = new();
  logic [POS_W-1:0] handed_out [$];   // recently allocated slots, targets for share/release
  bit               idle_mode;
  int               cycles = 0;

  always #5 clk = ~clk;

  slot_allocator_with_refcounts_core #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_slot    (out_slot),
    .out_freed   (out_freed),
    .out_status  (out_status)
  );

  // Result side: the receiver cannot stall, so every strobed beat is checked
  // on the edge that closes its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      ledger.check_reply(out_slot, out_freed, out_status);
  end

  // Watchdog. Also covers the reset sweep of the count memory.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one command beat and hold it until the block takes it. Start is
  // left high so back-to-back beats need no second assignment in one step.
  task automatic send(input func_t f, input logic [POS_W-1:0] p);
    reply_t r;
    start       <= 1'b1;
    in_func     <= f;
    in_position <= p;
    do @(posedge clk); while (busy !== 1'b0);
    r = ledger.take_request(f, p);
    if (f == FN_ALLOC && r.status == ST_OK) begin
      handed_out = {handed_out, r.slot};
      if (handed_out.size() > 64) void'(handed_out.pop_front());
    end
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random burst of sender idling, only while idle_mode is on.
  task automatic maybe_idle();
    if (idle_mode && $urandom_range(0, 3) == 0) idle($urandom_range(1, 18));
  endtask

  // Hold off until every owed reply is back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && handed_out.size() != 0)
      return handed_out[$urandom_range(0, handed_out.size() - 1)];
    else if (r < 80)
      return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    else
      return POS_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Mostly share/release of slots that are actually in use, some noise.
  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      send(FN_ALLOC, POS_W'($urandom_range(0, SLOTS - 1)));
    else if (r < 60) send(FN_SHARE, pick_pos());
    else if (r < 92) send(FN_RELEASE, pick_pos());
    else             send(FN_INVALID, POS_W'($urandom_range(0, SLOTS - 1)));
    maybe_idle();
  endtask

  // Random stretch; idling switches on and off in blocks of beats.
  task automatic random_run(input int n, input bit allow_idle);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_mode = allow_idle && ($urandom_range(0, 2) != 0);
      random_beat();
    end
  endtask

  initial begin
    idle_mode = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed beats ---
    send(FN_ALLOC, 10'd0);          // fresh slot 0
    send(FN_ALLOC, 10'd1023);       // fresh slot 1, position ignored
    send(FN_INVALID, 10'd1023);     // invalid request echoes position
    send(FN_INVALID, 10'd0);
    send(FN_SHARE, 10'd1);          // first share sets count to one
    send(FN_SHARE, 10'd1);
    send(FN_RELEASE, 10'd1);        // count above one: just decrement
    send(FN_RELEASE, 10'd1);        // count hits zero: freed, pushed
    send(FN_ALLOC, 10'd0);          // comes back out of the free FIFO
    send(FN_RELEASE, 10'd0);        // never shared: pushed at once, freed low
    send(FN_RELEASE, 10'd1023);
    send(FN_ALLOC, 10'd0);
    send(FN_ALLOC, 10'd0);
    send(FN_ALLOC, 10'd0);          // FIFO empty again, fresh slot 2
    send(FN_SHARE, 10'd0);
    send(FN_RELEASE, 10'd0);
    send(FN_SHARE, 10'h2AA);
    send(FN_SHARE, 10'h155);
    send(FN_RELEASE, 10'h2AA);
    send(FN_RELEASE, 10'h155);
    send(FN_ALLOC, 10'h155);
    send(FN_ALLOC, 10'h2AA);
    drain();

    // --- empty the FIFO, then run the bump counter dry ---
    idle_mode = 1'b1;
    while (ledger.fifo_fill != 0 || ledger.fresh_next < SLOTS) begin
      send(FN_ALLOC, POS_W'($urandom_range(0, SLOTS - 1)));
      if ($urandom_range(0, 15) == 0) send(FN_INVALID, POS_W'($urandom_range(0, SLOTS - 1)));
      maybe_idle();
    end
    send(FN_ALLOC, 10'd0);          // slots exhausted
    send(FN_ALLOC, 10'd1023);
    send(FN_RELEASE, 10'd5);        // never shared: pushed at once
    send(FN_ALLOC, 10'd0);          // pops slot 5 again

    // --- more random traffic, last stretch with no idling ---
    random_run(90, 1'b1);
    random_run(50, 1'b0);

    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
    repeat (8) @(posedge clk);
    if (ledger.outstanding() != 0)
      ledger.report($sformatf("%0d replies never arrived", ledger.outstanding()));

    if (ledger.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
